@@ hw/rtl/ditc_pkg.sv @@
package ditc_pkg;

   localparam int unsigned ExpBias   = 1023;

   typedef enum logic [2:0] {
      OP_DBL_TO_TORUS = 3'd0,
      OP_TORUS_TO_DBL = 3'd1,
      OP_DBL_TO_I32   = 3'd2,
      OP_I32_TO_DBL   = 3'd3,
      OP_DBL_TO_I64   = 3'd4,
      OP_I64_TO_DBL   = 3'd5
   } op_type;

   // stage 1 -> stage 2 control and data
   typedef struct packed {
      logic        to_dbl;
      logic        flag;
      logic        sign;
      logic        narrow;
      logic        zero;
      logic [6:0]  shift;
      logic [10:0] exp_base;
      logic [63:0] mag;
   } s1_type;

   // stage 2 -> stage 3
   typedef struct packed {
      logic        to_dbl;
      logic        flag;
      logic        sign;
      logic        narrow;
      logic        zero;
      logic        round_up;
      logic [10:0] exp_out;
      logic [63:0] mag;
   } s2_type;

endpackage

@@ hw/rtl/ditc_decode.sv @@
module ditc_decode (
   input  logic [2:0]         op,
   input  logic [63:0]        operand_bits,
   output ditc_pkg::s1_type   dec
);

   logic [10:0] e;
   logic [10:0] e_eff;
   logic [52:0] m;
   logic [63:0] ival;
   logic [63:0] iabs;
   logic [51:0] w;
   logic signed [12:0] s;
   logic [11:0] lim;
   logic [6:0]  lz;
   logic        found;

   always_comb begin
      e     = operand_bits[62:52];
      e_eff = (e == 11'd0) ? 11'd1 : e;
      m     = {(e != 11'd0), operand_bits[51:0]};
      dec   = '0;
      ival  = '0;
      w     = '0;
      lim   = 12'd0;
      s     = '0;
      // integer operand, sign-extended
      case (op)
         ditc_pkg::OP_I64_TO_DBL: begin
            w    = operand_bits[51:0] + 52'h8000000000000;
            ival = {{12{~w[51]}}, ~w[51], w[50:0]} ;
         end
         default: ival = {{32{operand_bits[31]}}, operand_bits[31:0]};
      endcase
      iabs = ival[63] ? (64'd0 - ival) : ival;
      // leading zero count
      lz    = 7'd64;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && iabs[i]) begin
            lz    = 7'(63 - i);
            found = 1'b1;
         end
      end
      case (op)
         ditc_pkg::OP_TORUS_TO_DBL, ditc_pkg::OP_I32_TO_DBL,
         ditc_pkg::OP_I64_TO_DBL: begin
            dec.to_dbl   = 1'b1;
            dec.sign     = ival[63];
            dec.zero     = (iabs == 64'd0);
            dec.shift    = lz;
            dec.mag      = iabs;
            dec.exp_base = (op == ditc_pkg::OP_TORUS_TO_DBL) ? 11'(ditc_pkg::ExpBias + 63 - 32)
                                                             : 11'(ditc_pkg::ExpBias + 63);
         end
         ditc_pkg::OP_DBL_TO_TORUS, ditc_pkg::OP_DBL_TO_I32,
         ditc_pkg::OP_DBL_TO_I64: begin
            if (op == ditc_pkg::OP_DBL_TO_TORUS) begin
               lim = 12'(ditc_pkg::ExpBias + 19);
               s   = 13'(e_eff) - 13'sd1075 + 13'sd32;
            end else begin
               lim = 12'(ditc_pkg::ExpBias + 50);
               s   = 13'(e_eff) - 13'sd1075;
            end
            dec.flag   = ({1'b0, e} >= lim);
            dec.sign   = operand_bits[63];
            dec.narrow = (op != ditc_pkg::OP_DBL_TO_I64);
            // shift code: bit6 set = left shift by low bits, else right shift
            if (s >= 0) begin
               dec.shift = {1'b1, 6'(s)};
            end else if (s <= -13'sd54) begin
               dec.shift = 7'd63;
            end else begin
               dec.shift = {1'b0, 6'(-s)};
            end
            dec.mag = {11'd0, m};
         end
         default: dec.flag = 1'b1;
      endcase
   end

endmodule

@@ hw/rtl/ditc_shift.sv @@
module ditc_shift (
   input  ditc_pkg::s1_type   s1,
   output ditc_pkg::s2_type   s2
);

   logic [63:0] nrm;
   logic [63:0] rem;
   logic [63:0] half;
   logic [63:0] q;
   logic [5:0]  r;

   always_comb begin
      s2        = '0;
      s2.to_dbl = s1.to_dbl;
      s2.flag   = s1.flag;
      s2.sign   = s1.sign;
      s2.narrow = s1.narrow;
      s2.zero   = s1.zero;
      nrm  = '0;
      rem  = '0;
      half = '0;
      q    = '0;
      r    = s1.shift[5:0];
      if (s1.to_dbl) begin
         // normalize, guard bits below fraction
         nrm        = s1.mag << s1.shift[5:0];
         s2.exp_out = s1.exp_base - 11'(s1.shift);
         s2.mag     = nrm;
         rem        = {53'd0, nrm[10:0]};
         half       = 64'h400;
         s2.round_up = (rem > half) || (rem == half && nrm[11]);
      end else if (s1.shift[6]) begin
         s2.mag = s1.mag << r;
      end else if (r == 6'd0) begin
         s2.mag = s1.mag;
      end else begin
         q    = s1.mag >> r;
         rem  = s1.mag & ((64'd1 << r) - 64'd1);
         half = 64'd1 << (r - 6'd1);
         s2.mag      = q;
         s2.round_up = (rem > half) || (rem == half && q[0]);
      end
   end

endmodule

@@ hw/rtl/ditc_finish.sv @@
module ditc_finish (
   input  ditc_pkg::s2_type s2,
   output logic [63:0]      result_bits,
   output logic             out_of_range
);

   logic [63:0] q;
   logic [63:0] sq;
   logic [53:0] fr;
   logic [10:0] ex;

   always_comb begin
      result_bits  = '0;
      out_of_range = s2.flag;
      q  = '0;
      sq = '0;
      fr = '0;
      ex = '0;
      if (s2.to_dbl) begin
         // round fraction; carry bumps exponent
         fr = {1'b0, s2.mag[63:11]} + 54'(s2.round_up);
         ex = s2.exp_out + 11'(fr[53]);
         if (!s2.zero) begin
            result_bits = fr[53] ? {s2.sign, ex, fr[52:1]} : {s2.sign, ex, fr[51:0]};
         end
      end else if (!s2.flag) begin
         q  = s2.mag + 64'(s2.round_up);
         sq = s2.sign ? (64'd0 - q) : q;
         result_bits = s2.narrow ? {{32{sq[31]}}, sq[31:0]} : sq;
      end
   end

endmodule

@@ hw/rtl/double_integer_torus_converter.sv @@
// Converts between IEEE-754 double bit patterns and integers; op selects
// double->torus32, torus32->double, double->int32, int32->double,
// double->int64 and int64->double. Round to nearest, ties to even. One beat in
// and one beat out per cycle while rsp_ready stays high; the stages are
// decode and leading-zero count, alignment shift and round decision,
// increment and packing, each stage a register with its own valid bit.
// Non-finite or too-large doubles and unused op codes give zero with
// out_of_range set.
module double_integer_torus_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_operand_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_bits,
   output logic        rsp_out_of_range
);

   ditc_pkg::s1_type s1_in, s1_ff;
   ditc_pkg::s2_type s2_in, s2_ff;
   logic [63:0] res_in, res_ff;
   logic        oor_in, oor_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic        en1, en2, en3;

   // pipeline advance, stall ripples back
   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   ditc_decode u_decode (
      .op           (req_op),
      .operand_bits (req_operand_bits),
      .dec          (s1_in)
   );

   ditc_shift u_shift (
      .s1 (s1_ff),
      .s2 (s2_in)
   );

   ditc_finish u_finish (
      .s2           (s2_ff),
      .result_bits  (res_in),
      .out_of_range (oor_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) begin
         res_ff <= res_in;
         oor_ff <= oor_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_result_bits  = res_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

@@ tb/conversion_checker.sv @@
`timescale 1ns / 1ps

module conversion_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_operand_bits,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_result_bits,
   input  logic        rsp_out_of_range,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [63:0] result_bits;
      logic        out_of_range;
   } conversion_type;

   conversion_type expected_results[$];

   // nearest integer of value(bits) * 2^k, ties to even, two's complement
   function automatic logic [63:0] scaled_nearest(logic [63:0] bits, int k);
      int          expo;
      int          sh;
      int          r;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mag;
      expo = int'(bits[62:52]);
      m    = {12'd0, bits[51:0]};
      if (expo == 0) begin
         expo = 1;
      end else begin
         m[52] = 1'b1;
      end
      sh = expo - 1075 + k;
      if (sh >= 0) begin
         mag = (sh < 10) ? (m << sh) : 64'd0;
      end else if (sh <= -54) begin
         mag = 64'd0;
      end else begin
         r    = -sh;
         q    = m >> r;
         rem  = m & ((64'd1 << r) - 64'd1);
         half = 64'd1 << (r - 1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
         end
         mag = q;
      end
      if (bits[63]) begin
         mag = 64'd0 - mag;
      end
      return mag;
   endfunction

   // exact double of v * 2^-scale; |v| stays below 2^52
   function automatic logic [63:0] exact_double(longint v, int scale);
      logic [63:0] mag;
      logic [63:0] frac;
      int          msb;
      if (v == 0) begin
         return 64'd0;
      end
      mag = (v < 0) ? 64'(-v) : 64'(v);
      msb = 0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) begin
            msb = i;
         end
      end
      frac = (mag << (52 - msb)) & ((64'd1 << 52) - 64'd1);
      return {v < 0, 11'(msb + 1023 - scale), frac[51:0]};
   endfunction

   function automatic conversion_type convert_item(logic [2:0] op, logic [63:0] a);
      conversion_type res;
      logic [63:0]    wrapped;
      res = '0;
      case (op)
         ditc_pkg::OP_DBL_TO_TORUS: begin
            if (a[62:52] >= 11'(ditc_pkg::ExpBias + 19)) begin
               res.out_of_range = 1'b1;
            end else begin
               wrapped         = scaled_nearest(a, 32);
               res.result_bits = {{32{wrapped[31]}}, wrapped[31:0]};
            end
         end
         ditc_pkg::OP_TORUS_TO_DBL:
            res.result_bits = exact_double(longint'(signed'(a[31:0])), 32);
         ditc_pkg::OP_DBL_TO_I32: begin
            if (a[62:52] >= 11'(ditc_pkg::ExpBias + 50)) begin
               res.out_of_range = 1'b1;
            end else begin
               wrapped         = scaled_nearest(a, 0);
               res.result_bits = {{32{wrapped[31]}}, wrapped[31:0]};
            end
         end
         ditc_pkg::OP_I32_TO_DBL:
            res.result_bits = exact_double(longint'(signed'(a[31:0])), 0);
         ditc_pkg::OP_DBL_TO_I64: begin
            if (a[62:52] >= 11'(ditc_pkg::ExpBias + 50)) begin
               res.out_of_range = 1'b1;
            end else begin
               res.result_bits = scaled_nearest(a, 0);
            end
         end
         ditc_pkg::OP_I64_TO_DBL: begin
            // wrap into the signed 52-bit window
            wrapped         = (a + (64'd1 << 51)) & ((64'd1 << 52) - 64'd1);
            res.result_bits = exact_double(longint'(wrapped) - (longint'(1) << 51), 0);
         end
         default: res.out_of_range = 1'b1;
      endcase
      return res;
   endfunction

   // predict on every input beat, compare on every result beat
   always @(posedge clock) begin
      conversion_type exp_res;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(convert_item(req_op, req_operand_bits));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat result_bits=%h out_of_range=%b",
                        $time, rsp_result_bits, rsp_out_of_range);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_results.pop_front();
               if (exp_res.result_bits !== rsp_result_bits ||
                   exp_res.out_of_range !== rsp_out_of_range) begin
                  if (exp_res.result_bits !== rsp_result_bits) begin
                     $display("%0t: result_bits expected %h actual %h",
                              $time, exp_res.result_bits, rsp_result_bits);
                  end
                  if (exp_res.out_of_range !== rsp_out_of_range) begin
                     $display("%0t: out_of_range expected %b actual %b",
                              $time, exp_res.out_of_range, rsp_out_of_range);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_results.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int NumRandom = 1950;
   localparam int CalmFrom  = 1750;
   localparam logic [2:0] OpUnusedLo = 3'd6;
   localparam logic [2:0] OpUnusedHi = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_op;
   logic [63:0] req_operand_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_bits;
   logic        rsp_out_of_range;
   logic        calm;
   int          fail_count;
   int          pending;
   int          rsp_beats;

   double_integer_torus_converter DUT (.*);

   conversion_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("double_integer_torus_converter regression: fail");
      $finish;
   end

   // offer one beat and hold it until accepted
   task automatic send_beat(logic [2:0] op, logic [63:0] operand);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_operand_bits <= operand;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clock);
   endtask

   // random operand leaning on the rounding and range boundaries
   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      int          r;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: ;
         1: v[62:52] = 11'($urandom_range(ditc_pkg::ExpBias - 45, ditc_pkg::ExpBias + 55));
         2: begin
            // exact tie at a random rounding position
            v[62:52] = 11'($urandom_range(ditc_pkg::ExpBias - 40, ditc_pkg::ExpBias + 52));
            r = $urandom_range(1, 52);
            v = (v & ~((64'd1 << r) - 64'd1)) | (64'd1 << (r - 1));
         end
         3: begin
            case ($urandom_range(0, 5))
               0: v[62:52] = 11'h7FF;
               1: v[62:52] = 11'd0;
               2: v[62:52] = 11'(ditc_pkg::ExpBias + 19);
               3: v[62:52] = 11'(ditc_pkg::ExpBias + 18);
               4: v[62:52] = 11'(ditc_pkg::ExpBias + 50);
               default: v[62:52] = 11'(ditc_pkg::ExpBias + 49);
            endcase
         end
         4: v = 64'($signed($urandom_range(0, 200)) - 100);
         default: v[63:51] = {13{v[51]}};
      endcase
      return v;
   endfunction

   // receiver: random stalls, one long hold-off to back up the pipe
   initial begin
      int  hold;
      bit  held_long;
      hold      = 0;
      held_long = 0;
      rsp_beats = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) rsp_beats++;
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!held_long && rsp_beats >= 600) begin
            held_long = 1;
            hold      = 119;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [63:0] directed_operand[$];
      logic [2:0]  directed_op[$];
      logic [2:0]  op;
      calm             = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= ditc_pkg::OP_DBL_TO_TORUS;
      req_operand_bits <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ties, signed zero, subnormal, non-finite, range edges
      directed_op = {ditc_pkg::OP_DBL_TO_TORUS, ditc_pkg::OP_DBL_TO_TORUS,
                     ditc_pkg::OP_DBL_TO_TORUS, ditc_pkg::OP_DBL_TO_TORUS,
                     ditc_pkg::OP_DBL_TO_TORUS, ditc_pkg::OP_DBL_TO_TORUS,
                     ditc_pkg::OP_DBL_TO_TORUS, ditc_pkg::OP_DBL_TO_TORUS,
                     ditc_pkg::OP_TORUS_TO_DBL, ditc_pkg::OP_TORUS_TO_DBL,
                     ditc_pkg::OP_TORUS_TO_DBL,
                     ditc_pkg::OP_DBL_TO_I32, ditc_pkg::OP_DBL_TO_I32,
                     ditc_pkg::OP_DBL_TO_I32, ditc_pkg::OP_DBL_TO_I32,
                     ditc_pkg::OP_I32_TO_DBL, ditc_pkg::OP_I32_TO_DBL,
                     ditc_pkg::OP_DBL_TO_I64, ditc_pkg::OP_DBL_TO_I64,
                     ditc_pkg::OP_DBL_TO_I64,
                     ditc_pkg::OP_I64_TO_DBL, ditc_pkg::OP_I64_TO_DBL,
                     ditc_pkg::OP_I64_TO_DBL, OpUnusedLo, OpUnusedHi};
      directed_operand = {64'h3DE0_0000_0000_0000, 64'h3DF8_0000_0000_0000,
                          64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                          64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0000,
                          64'h4120_0000_0000_0000, 64'hC11F_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_8000_0000, 64'h0000_0000_7FFF_FFFF, 64'd0,
                          64'h4004_0000_0000_0000, 64'hC004_0000_0000_0000,
                          64'h4310_0000_0000_0000, 64'h430F_FFFF_FFFF_FFFF,
                          64'hABCD_0123_8000_0000, 64'd0,
                          64'hC30F_FFFF_FFFF_FFFF, 64'hFFF0_0000_0000_0000,
                          64'h3FE0_0000_0000_0000,
                          64'h0008_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'h7FFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
                          64'hFFFF_FFFF_FFFF_FFFF};
      foreach (directed_op[i]) begin
         send_beat(directed_op[i], directed_operand[i]);
         if ($urandom_range(0, 2) == 0) sender_gap();
      end

      // random part, no idling toward the end
      for (int i = 0; i < NumRandom; i++) begin
         if (i == CalmFrom) calm = 1'b1;
         op = ($urandom_range(0, 19) == 0) ? (($urandom_range(0, 1) == 0) ? OpUnusedLo
                                                                           : OpUnusedHi)
                                           : 3'($urandom_range(0, 5));
         send_beat(op, pick_operand());
         if (!calm && $urandom_range(0, 4) == 0) sender_gap();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("double_integer_torus_converter regression: pass");
      end else begin
         $display("double_integer_torus_converter regression: fail");
      end
      $finish;
   end

endmodule
